// ===== design/tage_pkg.sv =====
package tage_pkg;

  localparam int NumTables   = 6;
  localparam int TableSize   = 1024;
  localparam int BimodalSize = 4096;
  localparam int MinHist     = 4;
  localparam int MaxHist     = 128;

  localparam int PcW      = 32;
  localparam int PeriodW  = 21;
  localparam int SeedW    = 16;
  localparam int CountW   = 21;
  localparam int PathW    = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 21;
  localparam int ProvW    = 3;

  localparam logic [PeriodW-1:0] PeriodReset = 21'd262144;
  localparam logic [SeedW-1:0]   SeedReset   = 16'd44257;
  localparam logic [SeedW-1:0]   LfsrTaps    = 16'hB400;

  localparam logic [CfgIdxW-1:0] CfgPeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSeed   = 1'b1;

  // one accepted branch passed from front to back
  typedef struct packed {
    logic [PcW-1:0] pc;
    logic           taken;
  } br_t;

  // Integer history length of table b: smallest len with
  // (2len+1)^(n-1) > 2^(n-1) * min^(n-1-b) * max^b, then capped.
  // Exact wide-integer compare, evaluated at elaboration.
  function automatic int hist_len(input int b, input int n, input int mn, input int mx);
    logic [255:0] lhs;
    logic [255:0] rhs;
    int           len;
    bit           fits;
    len  = 1;
    fits = 1'b1;
    while (len < 2048 && fits) begin
      lhs = 256'd1;
      rhs = 256'd1;
      for (int k = 0; k < n - 1; k++) begin
        lhs = lhs * 256'(2 * len + 1);
        rhs = rhs * 256'd2 * 256'((k < n - 1 - b) ? mn : mx);
      end
      fits = (lhs <= rhs);
      if (fits) len++;
    end
    if (len > mx) len = mx;
    return len;
  endfunction

endpackage

// ===== design/tage_front.sv =====
// Input queue front: two-entry FIFO of accepted branches.
module tage_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  tage_pkg::br_t   br_i,
  output logic            avail_o,
  input  logic            take_i,
  output tage_pkg::br_t   br_o
);
  tage_pkg::br_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign wr      = push_i && !full_o;
  assign rd      = take_i && avail_o;
  assign br_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= br_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("front count overflow");
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> avail_o) else $error("write lost");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd && !wr && cnt_q == 2'd1) |=> !avail_o) else $error("read lost");
`endif
endmodule

// ===== design/tage_back.sv =====
// Back end: sequencer over init / read / update / clear phases.
module tage_back #(
  parameter int NumTables   = tage_pkg::NumTables,
  parameter int TableSize   = tage_pkg::TableSize,
  parameter int BimodalSize = tage_pkg::BimodalSize,
  parameter int MinHist     = tage_pkg::MinHist,
  parameter int MaxHist     = tage_pkg::MaxHist
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           avail_i,
  input  tage_pkg::br_t                  br_i,
  output logic                           take_o,
  input  logic                           cfg_we_i,
  input  logic [tage_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tage_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           res_valid_o,
  input  logic                           res_take_i,
  output logic                           predicted_taken_o,
  output logic [tage_pkg::ProvW-1:0]     provider_table_o,
  output logic                           alternate_used_o,
  output logic                           mispredicted_o
);
  localparam int IdxW     = $clog2(TableSize);
  localparam int BiW      = $clog2(BimodalSize);
  localparam int TagW     = 9 + (NumTables - 1) / 2;
  localparam int SweepMax = (TableSize > BimodalSize) ? TableSize : BimodalSize;
  localparam int SwW      = $clog2(SweepMax + 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_UPD, S_CLEAR
  } state_e;

  state_e state_q;

  logic [1:0] bim_mem [BimodalSize];

  logic [MaxHist-1:0]           ghist_q;
  logic [tage_pkg::PathW-1:0]   path_q;
  logic [tage_pkg::CountW-1:0]  count_q;
  logic                         clr_high_q;
  logic [tage_pkg::SeedW-1:0]   lfsr_q;
  logic [tage_pkg::PeriodW-1:0] period_q;
  logic [SwW-1:0]               sweep_q;

  tage_pkg::br_t br_q;
  logic [IdxW-1:0] idx_q   [NumTables];
  logic [TagW-1:0] ctag_q  [NumTables];
  logic [TagW-1:0] rtag    [NumTables];
  logic [2:0]      rctr    [NumTables];
  logic [1:0]      ru      [NumTables];
  logic [1:0]      rbim_q;

  logic                       res_q, pred_q, alt_q, mis_q;
  logic [tage_pkg::ProvW-1:0] prov_out_q;

  // hash per table, driven from the bank blocks
  logic [IdxW-1:0] idx_c  [NumTables];
  logic [TagW-1:0] ctag_c [NumTables];

  // x mod 3 is the sum of its base-4 digits mod 3
  function automatic logic mod3_zero(input logic [tage_pkg::SeedW-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int k = 0; k < 8; k++) s = s + 5'(v[2*k +: 2]);
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    return (u == 3'd0) || (u == 3'd3);
  endfunction

  // decision on registered reads
  logic            hit [NumTables];
  int              prov, alt;
  logic            bim_pred, prov_pred, alt_pred, fin_pred, alt_used, mis;
  logic [2:0]      pctr_n;
  logic [1:0]      pu_n;
  int              pick;
  logic [tage_pkg::SeedW-1:0] lfsr_n;
  logic            lfsr_adv;
  always_comb begin
    for (int b = 0; b < NumTables; b++) hit[b] = (rtag[b] == ctag_q[b]);
    prov = -1; alt = -1;
    for (int b = NumTables - 1; b >= 0; b--) begin
      if (hit[b]) begin
        if (prov < 0) prov = b;
        else if (alt < 0) alt = b;
      end
    end
    bim_pred  = rbim_q[1];
    prov_pred = (prov < 0) ? bim_pred : !rctr[prov][2];
    alt_pred  = (alt < 0) ? bim_pred : !rctr[alt][2];
    fin_pred  = prov_pred;
    alt_used  = 1'b0;
    pctr_n = 3'd0; pu_n = 2'd0;
    if (prov >= 0) begin
      pctr_n = rctr[prov];
      pu_n   = ru[prov];
      if (ru[prov] == 2'd0 && (rctr[prov] == 3'd0 || rctr[prov] == 3'b111)) begin
        fin_pred = alt_pred; alt_used = 1'b1;
      end
      if (br_q.taken && rctr[prov] != 3'd3) pctr_n = rctr[prov] + 3'd1;
      else if (!br_q.taken && rctr[prov] != 3'b100) pctr_n = rctr[prov] - 3'd1;
      if (fin_pred != alt_pred) begin
        if (fin_pred == br_q.taken) begin
          if (ru[prov] != 2'd3) pu_n = ru[prov] + 2'd1;
        end else if (ru[prov] != 2'd0) pu_n = ru[prov] - 2'd1;
      end
    end
    mis = fin_pred != br_q.taken;
    pick = -1; lfsr_adv = 1'b0;
    lfsr_n = (lfsr_q >> 1) ^ (lfsr_q[0] ? tage_pkg::LfsrTaps : '0);
    if (mis) begin
      for (int b = 0; b < NumTables; b++) begin
        if (b > prov && ru[b] == 2'd0 && !lfsr_adv) begin
          if (pick < 0) pick = b;
          else begin
            lfsr_adv = 1'b1;
            if (mod3_zero(lfsr_n)) pick = b;
          end
        end
      end
    end
  end

  logic [tage_pkg::CountW-1:0] cnt_inc;
  assign cnt_inc = count_q + 1'b1;
  assign take_o  = (state_q == S_IDLE) && avail_i;
  assign res_valid_o       = res_q;
  assign predicted_taken_o = pred_q;
  assign provider_table_o  = prov_out_q;
  assign alternate_used_o  = alt_q;
  assign mispredicted_o    = mis_q;

  // tag, counter and usefulness memories per bank, all banks read in parallel
  for (genvar g = 0; g < NumTables; g++) begin : g_bank
    localparam int HistLen = tage_pkg::hist_len(g, NumTables, MinHist, MaxHist);
    logic [TagW-1:0] tag_mem [TableSize];
    logic [2:0]      ctr_mem [TableSize];
    logic [1:0]      u_mem   [TableSize];
    logic [TagW-1:0] rtag_q;
    logic [2:0]      rctr_q;
    logic [1:0]      ru_q;
    logic [31:0]     h_c, t_c;

    always_comb begin
      h_c = br_i.pc;
      t_c = br_i.pc ^ (br_i.pc >> 4);
      for (int i = 0; i < HistLen; i++) begin
        if (ghist_q[i]) begin
          h_c[i % 9] = ~h_c[i % 9];
          t_c[(i * 7 + g) % 10] = ~t_c[(i * 7 + g) % 10];
        end
      end
      h_c = h_c ^ ({16'd0, path_q} << g);
    end

    assign idx_c[g]  = h_c[IdxW-1:0];
    assign ctag_c[g] = TagW'(t_c & ((32'd1 << (9 + g / 2)) - 32'd1));

    always_ff @(posedge clk_i) begin
      if (state_q == S_INIT) begin
        if (sweep_q < SwW'(TableSize)) begin
          tag_mem[sweep_q[IdxW-1:0]] <= '0;
          ctr_mem[sweep_q[IdxW-1:0]] <= '0;
          u_mem[sweep_q[IdxW-1:0]]   <= '0;
        end
      end else if (state_q == S_CLEAR) begin
        // read entry k while writing back entry k-1
        if (sweep_q < SwW'(TableSize)) ru_q <= u_mem[sweep_q[IdxW-1:0]];
        if (sweep_q != '0)
          u_mem[IdxW'(sweep_q - 1'b1)] <= ru_q & (clr_high_q ? 2'b01 : 2'b10);
      end else if (take_o) begin
        rtag_q <= tag_mem[idx_c[g]];
        rctr_q <= ctr_mem[idx_c[g]];
        ru_q   <= u_mem[idx_c[g]];
      end else if (state_q == S_UPD) begin
        if (g == prov) begin
          ctr_mem[idx_q[g]] <= pctr_n;
          u_mem[idx_q[g]]   <= pu_n;
        end else if (g == pick) begin
          tag_mem[idx_q[g]] <= ctag_q[g];
          ctr_mem[idx_q[g]] <= br_q.taken ? 3'd0 : 3'b111;
          u_mem[idx_q[g]]   <= 2'd0;
        end else if (mis && pick < 0 && g > prov && ru_q != 2'd0) begin
          u_mem[idx_q[g]] <= ru_q - 2'd1;
        end
      end
    end

    assign rtag[g] = rtag_q;
    assign rctr[g] = rctr_q;
    assign ru[g]   = ru_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT) begin
      if (sweep_q < SwW'(BimodalSize)) bim_mem[sweep_q[BiW-1:0]] <= 2'd2;
    end else if (take_o) begin
      rbim_q <= bim_mem[br_i.pc[BiW-1:0]];
    end else if (state_q == S_UPD && prov < 0) begin
      if (br_q.taken && rbim_q != 2'd3) bim_mem[br_q.pc[BiW-1:0]] <= rbim_q + 2'd1;
      else if (!br_q.taken && rbim_q != 2'd0)
        bim_mem[br_q.pc[BiW-1:0]] <= rbim_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      br_q <= br_i;
      for (int b = 0; b < NumTables; b++) begin
        idx_q[b] <= idx_c[b]; ctag_q[b] <= ctag_c[b];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; sweep_q <= '0;
      ghist_q <= '0; path_q <= '0; count_q <= '0; clr_high_q <= 1'b1;
      lfsr_q <= tage_pkg::SeedReset;
      period_q <= tage_pkg::PeriodReset;
      res_q <= 1'b0; pred_q <= 1'b0; alt_q <= 1'b0; mis_q <= 1'b0;
      prov_out_q <= '0;
    end else begin
      if (res_q && res_take_i) res_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == tage_pkg::CfgPeriod) period_q <= cfg_data_i;
        else lfsr_q <= cfg_data_i[tage_pkg::SeedW-1:0];
      end
      unique case (state_q)
        S_INIT: begin
          if (sweep_q >= SwW'(SweepMax)) begin
            sweep_q <= '0; state_q <= S_IDLE;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end
        S_IDLE: if (take_o) state_q <= S_READ;
        // hold the decision while the previous result still waits
        S_READ: if (!res_q || res_take_i) state_q <= S_UPD;
        S_UPD: begin
          res_q <= 1'b1; pred_q <= fin_pred; alt_q <= alt_used; mis_q <= mis;
          prov_out_q <= tage_pkg::ProvW'(prov + 1);
          if (lfsr_adv) lfsr_q <= lfsr_n;
          ghist_q <= {ghist_q[MaxHist-2:0], br_q.taken};
          path_q  <= {path_q[tage_pkg::PathW-2:0], br_q.pc[2]};
          if (32'(cnt_inc) >= 32'(period_q)) begin
            count_q <= '0; sweep_q <= '0; state_q <= S_CLEAR;
          end else begin
            count_q <= cnt_inc; state_q <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (sweep_q == SwW'(TableSize)) begin
            sweep_q <= '0; clr_high_q <= ~clr_high_q; state_q <= S_IDLE;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end
        default: state_q <= S_INIT;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> state_q == S_READ) else $error("take without read");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |=> res_q) else $error("result missing");
  a_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> !res_q) else $error("update over pending result");
`endif
endmodule

// ===== design/tage_branch_predictor.sv =====
// TAGE conditional branch predictor, trained on resolved branches.
// Input channel: push with pc_i/taken_i, accepted when push && !full.
// Output channel: one result per branch, valid while !empty, taken by pop.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i; index 0 sets the usefulness
// clear period, index 1 the LFSR seed (also reloads the LFSR). Write only idle.
// A two-entry input queue decouples acceptance from the back end.
// Back end: when idle it takes a branch from the queue and reads all banks
// at once, then a read state decides and an update state writes back; a new
// branch is taken only once the previous one is updated. The result register
// lets the next branch be read while the previous result waits; its update
// holds until that result is popped.
// Every period, a usefulness clear sweeps all banks in parallel, stalling
// the back end while it runs.
// After reset the tables are initialised by a sweep over all entries
// before the first branch is processed; the input queue still accepts up
// to two branches meanwhile.
// A stalled receiver holds the result and, once the queue fills, full.
module tage_branch_predictor #(
  parameter int NumTables   = tage_pkg::NumTables,
  parameter int TableSize   = tage_pkg::TableSize,
  parameter int BimodalSize = tage_pkg::BimodalSize,
  parameter int MinHist     = tage_pkg::MinHist,
  parameter int MaxHist     = tage_pkg::MaxHist
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [tage_pkg::PcW-1:0]      pc_i,
  input  logic                          taken_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          predicted_taken_o,
  output logic [tage_pkg::ProvW-1:0]    provider_table_o,
  output logic                          alternate_used_o,
  output logic                          mispredicted_o,
  input  logic                          cfg_we_i,
  input  logic [tage_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tage_pkg::CfgDataW-1:0] cfg_data_i
);
  tage_pkg::br_t in_br, q_br;
  logic avail, take, res_valid;

  assign in_br.pc    = pc_i;
  assign in_br.taken = taken_i;
  assign empty       = !res_valid;

  tage_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .br_i(in_br),
    .avail_o(avail), .take_i(take), .br_o(q_br)
  );

  tage_back #(
    .NumTables(NumTables), .TableSize(TableSize), .BimodalSize(BimodalSize),
    .MinHist(MinHist), .MaxHist(MaxHist)
  ) u_back (
    .clk_i, .rst_ni, .avail_i(avail), .br_i(q_br), .take_o(take),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .res_valid_o(res_valid), .res_take_i(pop),
    .predicted_taken_o, .provider_table_o, .alternate_used_o, .mispredicted_o
  );
endmodule
